[rtl/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pdc_pkg.sv]
`default_nettype none

package pdc_pkg;

  typedef struct packed {
    logic [9:0] sensor_sample;
    logic       start_capture;
  } item_t;

  typedef struct packed {
    logic [15:0] duty_compare;
    logic        capture_valid;
    logic [9:0]  capture_sample;
    logic [9:0]  capture_reference;
    logic [7:0]  capture_point;
    logic        capture_done;
  } result_t;

  typedef enum logic [2:0] {
    CFG_KP_GAIN,
    CFG_KI_GAIN,
    CFG_PWM_PERIOD,
    CFG_REF_HIGH,
    CFG_REF_LOW,
    CFG_INTEG_CLAMP
  } cfg_idx_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KP_ERR,
    MUL_KI_ACC,
    MUL_V_PER,
    MUL_Y_RECIP,
    MUL_Q_HUND
  } mul_sel_t;

  typedef enum logic {
    SEQ_NEXT,     // advance to next step
    SEQ_END       // finish; hold here while the result register is full
  } seq_op_t;

  typedef struct packed {
    mul_sel_t mul;
    logic     ld_acc;   // clamp integral
    logic     ld_u;     // u = P term + feedforward
    logic     ld_v;     // v = clamp(u + I term)
    logic     ld_y;     // y = v*period >> 8
    logic     ld_q;     // q estimate of y/100
    seq_op_t  seq;
  } ucode_t;

  localparam ucode_t UC_IDLE = '{MUL_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT};

  localparam int          STEP_W      = 3;
  localparam int          U_W         = 30;
  localparam logic signed [U_W-1:0] FEEDFWD_Q8 = 30'sd12800;
  localparam logic signed [U_W-1:0] FULL_Q8    = 30'sd25600;
  // floor(2^24 / 100); estimate is exact or one low
  localparam logic [17:0] RECIP_100   = 18'd167772;
  localparam logic [6:0]  HUNDRED     = 7'd100;

  // Control store: one word per step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = UC_IDLE;
    case (step)
      3'd0: begin w.ld_acc = 1'b1; w.mul = MUL_KP_ERR; end
      3'd1: begin w.ld_u = 1'b1; w.mul = MUL_KI_ACC; end
      3'd2: begin w.ld_v = 1'b1; end
      3'd3: begin w.mul = MUL_V_PER; end
      3'd4: begin w.ld_y = 1'b1; w.mul = MUL_Y_RECIP; end
      3'd5: begin w.ld_q = 1'b1; w.mul = MUL_Q_HUND; end
      3'd6: begin w.seq = SEQ_END; end
      default: begin w = UC_IDLE; end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/pi_duty_controller_with_capture_unit.sv]
// PI duty controller with decimated capture.
// item channel (item_valid/item_ready/item): one control tick per transaction,
//   carrying the sensor sample and a capture start flag.
// result channel (result_valid/result_ready/result): one transaction per tick
//   with the PWM compare value and an optional capture point.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   ready whenever reset is low; indexes beyond the last register are dropped.
// A microcoded program runs the gain, scaling and reciprocal products through
//   one 24x24 multiplier, at most one product per step, and writes the result
//   to the output register at its final step; item_ready stays low while the
//   program runs, so a new item is not taken until the program finishes.
// The next item can be accepted while a result waits in the output register.
// If the receiver stalls, the final step holds the program until the output
//   register frees up; item_ready stays low meanwhile.
// Reset (synchronous, rst high) restores register defaults, clears the
//   waveform position, integral and capture state, and drops any result.
`default_nettype none
`include "assert_macros.svh"

module pi_duty_controller_with_capture_unit
  import pdc_pkg::*;
#(
  parameter int WAVE_LEN       = 1000,
  parameter int CAPTURE_POINTS = 200,
  parameter int DECIMATE       = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [10:0] WAVE_END  = 11'(WAVE_LEN);
  localparam logic [10:0] WAVE_HALF = 11'(WAVE_LEN / 2);
  localparam logic [7:0]  CAP_PTS   = 8'(CAPTURE_POINTS);
  localparam logic [3:0]  DEC_CNT   = 4'(DECIMATE);

  // configuration registers
  logic signed [15:0] kp_gain;
  logic signed [15:0] ki_gain;
  logic [15:0]        pwm_period;
  logic [9:0]         ref_high;
  logic [9:0]         ref_low;
  logic [8:0]         integ_clamp;

  // architectural state
  logic [9:0]         wave_position;
  logic signed [9:0]  error_integral;
  logic               capturing;
  logic [3:0]         decimate_count;
  logic [7:0]         point_count;

  // per-tick datapath registers
  logic [9:0]         sample_r;
  logic               start_r;
  logic [9:0]         ref_r;
  logic signed [10:0] err_r;
  logic signed [9:0]  acc_r;
  logic signed [U_W-1:0] u;
  logic [14:0]        v;
  logic [22:0]        y;
  logic [16:0]        q;
  logic signed [47:0] p;

  logic   busy;
  ucode_t ctl;
  logic   launch;
  logic   out_full;
  logic   commit;

  assign cfg_ready  = !rst;
  assign item_ready = !busy && !rst;
  assign launch     = item_valid && item_ready;
  assign out_full   = result_valid && !result_ready;
  assign commit     = busy && (ctl.seq == SEQ_END) && !out_full;

  pdc_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .launch   (launch),
    .out_full (out_full),
    .busy     (busy),
    .ctl      (ctl)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain     <= 16'sd0;
      ki_gain     <= 16'sd0;
      pwm_period  <= 16'd2399;
      ref_high    <= 10'd766;
      ref_low     <= 10'd256;
      integ_clamp <= 9'd400;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KP_GAIN:     kp_gain     <= cfg_data;
        CFG_KI_GAIN:     ki_gain     <= cfg_data;
        CFG_PWM_PERIOD:  pwm_period  <= cfg_data;
        CFG_REF_HIGH:    ref_high    <= cfg_data[9:0];
        CFG_REF_LOW:     ref_low     <= cfg_data[9:0];
        CFG_INTEG_CLAMP: integ_clamp <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Square-wave reference: high level in the first half of the period.
  logic [9:0]         ref_sel;
  logic signed [10:0] err_in;

  assign ref_sel = ({1'b0, wave_position} < WAVE_HALF) ? ref_high : ref_low;
  assign err_in  = $signed({1'b0, ref_sel}) - $signed({1'b0, item.sensor_sample});

  // Integral accumulate and symmetric clamp.
  logic signed [11:0] isum;
  logic signed [11:0] lim_pos;
  logic signed [11:0] lim_neg;
  logic signed [9:0]  acc_clamped;

  always_comb begin
    isum    = {{2{error_integral[9]}}, error_integral} + {err_r[10], err_r};
    lim_pos = $signed({3'b000, integ_clamp});
    lim_neg = 12'sd0 - lim_pos;
    if (isum > lim_pos) begin
      acc_clamped = lim_pos[9:0];
    end else if (isum < lim_neg) begin
      acc_clamped = lim_neg[9:0];
    end else begin
      acc_clamped = isum[9:0];
    end
  end

  // PI sum with feedforward, clamped to 0..100% (Q.8).
  logic signed [U_W-1:0] usum;
  logic [14:0]           v_clamped;

  always_comb begin
    usum = u + p[U_W-1:0];
    if (usum > FULL_Q8) begin
      v_clamped = FULL_Q8[14:0];
    end else if (usum < 0) begin
      v_clamped = '0;
    end else begin
      v_clamped = usum[14:0];
    end
  end

  // Shared multiplier operand select.
  logic signed [23:0] mul_a;
  logic signed [23:0] mul_b;

  always_comb begin
    case (ctl.mul)
      MUL_KP_ERR: begin
        mul_a = {{8{kp_gain[15]}}, kp_gain};
        mul_b = {{13{err_r[10]}}, err_r};
      end
      MUL_KI_ACC: begin
        mul_a = {{8{ki_gain[15]}}, ki_gain};
        mul_b = {{14{acc_r[9]}}, acc_r};
      end
      MUL_V_PER: begin
        mul_a = {9'd0, v};
        mul_b = {8'd0, pwm_period};
      end
      MUL_Y_RECIP: begin
        mul_a = {1'b0, p[30:8]};
        mul_b = {6'd0, RECIP_100};
      end
      MUL_Q_HUND: begin
        mul_a = {7'd0, p[40:24]};
        mul_b = {17'd0, HUNDRED};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (launch) begin
      sample_r <= item.sensor_sample;
      start_r  <= item.start_capture;
      ref_r    <= ref_sel;
      err_r    <= err_in;
    end
    if (ctl.mul != MUL_NONE) begin
      p <= mul_a * mul_b;
    end
    if (ctl.ld_acc) begin
      acc_r <= acc_clamped;
    end
    if (ctl.ld_u) begin
      u <= p[U_W-1:0] + FEEDFWD_Q8;
    end
    if (ctl.ld_v) begin
      v <= v_clamped;
    end
    if (ctl.ld_y) begin
      y <= p[30:8];
    end
    if (ctl.ld_q) begin
      q <= p[40:24];
    end
  end

  // Quotient fix-up: estimate of y/100 is exact or one low.
  logic [23:0] rem;
  logic [16:0] q_fix;

  assign rem   = {1'b0, y} - p[23:0];
  assign q_fix = q + 17'(rem >= 24'(HUNDRED));

  // Capture and waveform bookkeeping, applied when the result is written.
  logic        cap_on;
  logic [3:0]  dec_inc;
  logic [3:0]  decimate_count_next;
  logic [7:0]  point_count_next;
  logic        capturing_next;
  logic        cap_valid;
  logic        cap_done;
  logic [7:0]  cap_idx;
  logic [10:0] wave_inc;
  logic [9:0]  wave_position_next;

  always_comb begin
    cap_on              = capturing || start_r;
    dec_inc             = decimate_count + 4'd1;
    decimate_count_next = decimate_count;
    point_count_next    = point_count;
    capturing_next      = cap_on;
    cap_valid           = 1'b0;
    cap_done            = 1'b0;
    cap_idx             = '0;
    if (cap_on) begin
      decimate_count_next = dec_inc;
      if (dec_inc >= DEC_CNT) begin
        decimate_count_next = '0;
        cap_valid           = 1'b1;
        cap_idx             = point_count;
        point_count_next    = point_count + 8'd1;
      end
      if (point_count_next >= CAP_PTS) begin
        point_count_next = '0;
        capturing_next   = 1'b0;
        cap_done         = cap_valid;
      end
    end
    wave_inc = {1'b0, wave_position} + 11'd1;
    wave_position_next = (wave_inc >= WAVE_END) ? 10'd0 : wave_inc[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_position  <= '0;
      error_integral <= '0;
      capturing      <= 1'b0;
      decimate_count <= '0;
      point_count    <= '0;
    end else if (commit) begin
      wave_position  <= wave_position_next;
      error_integral <= acc_r;
      capturing      <= capturing_next;
      decimate_count <= decimate_count_next;
      point_count    <= point_count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.duty_compare      <= q_fix[15:0];
      result.capture_valid     <= cap_valid;
      result.capture_sample    <= cap_valid ? sample_r : 10'd0;
      result.capture_reference <= cap_valid ? ref_r : 10'd0;
      result.capture_point     <= cap_idx;
      result.capture_done      <= cap_done;
    end
  end

  // Checks.
  `CHK_NEXT(a_accept_starts, launch, busy, "accepted transaction did not start the program")
  `CHK_IMPL(a_wave_range, 1'b1, ({1'b0, wave_position} < WAVE_END), "wave position out of range")
  `CHK_IMPL(a_dec_range, 1'b1, (decimate_count < DEC_CNT), "decimation count out of range")
  `CHK_IMPL(a_done_last, (result_valid && result.capture_done), (result.capture_valid && (result.capture_point == CAP_PTS - 8'd1)), "capture done not on last point")

endmodule

`default_nettype wire

[rtl/pdc_sequencer.sv]
`default_nettype none

module pdc_sequencer
  import pdc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   launch,     // transaction accepted, start program
  input  wire logic   out_full,   // result register cannot take a word
  output logic        busy,
  output ucode_t      ctl
);

  logic [STEP_W-1:0] step;

  always_comb begin
    ctl = busy ? ucode_rom(step) : UC_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (launch) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      case (ctl.seq)
        SEQ_END: begin
          if (!out_full) begin
            busy <= 1'b0;
          end
        end
        SEQ_NEXT: begin
          step <= step + STEP_W'(1);
        end
        default: begin
          busy <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
